// ===== sv/qte_pkg.sv =====
// Shared types, constants and angle table for the quaternion to Euler block.
`default_nettype none
package qte_pkg;

  // CORDIC iteration count, capped by the angle table length
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS : ANG_TABLE_LEN;

  // Datapath widths: CORDIC vector, angle accumulator (Q.24), iteration index
  localparam int CW = 37;
  localparam int ZW = 30;
  localparam int IW = 5;

  // Angle and scale constants
  localparam logic signed [ZW-1:0] PI_Q24      = ZW'(52707179);
  localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
  localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [16:0]   JUMP_LIMIT  = 17'sd12867;
  localparam logic signed [31:0]   TWO_PI_Q13  = 32'sd51472;
  localparam logic signed [31:0]   ONE_Q30     = 32'sd1073741824;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SQ,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_ROLL_GO,
    S_ROLL_WAIT,
    S_PITCH_GO,
    S_PITCH_WAIT,
    S_YAW_GO,
    S_YAW_WAIT,
    S_UNW,
    S_SUM,
    S_OUT
  } state_t;

  // atan(2^-i) in Q.24
  function automatic logic signed [ZW-1:0] atan_q24(input logic [IW-1:0] i);
    logic signed [ZW-1:0] a;
    unique case (i)
      5'd0:  a = ZW'(13176795);
      5'd1:  a = ZW'(7778716);
      5'd2:  a = ZW'(4110060);
      5'd3:  a = ZW'(2086331);
      5'd4:  a = ZW'(1047214);
      5'd5:  a = ZW'(524117);
      5'd6:  a = ZW'(262123);
      5'd7:  a = ZW'(131069);
      5'd8:  a = ZW'(65536);
      5'd9:  a = ZW'(32768);
      5'd10: a = ZW'(16384);
      5'd11: a = ZW'(8192);
      5'd12: a = ZW'(4096);
      5'd13: a = ZW'(2048);
      5'd14: a = ZW'(1024);
      5'd15: a = ZW'(512);
      5'd16: a = ZW'(256);
      5'd17: a = ZW'(128);
      5'd18: a = ZW'(64);
      5'd19: a = ZW'(32);
      5'd20: a = ZW'(16);
      5'd21: a = ZW'(8);
      5'd22: a = ZW'(4);
      5'd23: a = ZW'(2);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== sv/qte_if.sv =====
// Valid/ready channel interfaces for quaternion input and Euler result words.
`default_nettype none
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_wrapped;
  logic signed [15:0] turn_count;
  logic signed [31:0] yaw_unwrapped;
  logic               pitch_clamped;
  modport source(output valid, roll_angle, pitch_angle, yaw_wrapped, turn_count,
                 yaw_unwrapped, pitch_clamped, input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_wrapped, turn_count,
               yaw_unwrapped, pitch_clamped, output ready);
endinterface
`default_nettype wire

// ===== sv/qte_cordic.sv =====
// Iterative vectoring CORDIC: atan2(y, x) in Q3.13, one rotation per cycle.
`default_nettype none
module qte_cordic (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [qte_pkg::CW-1:0] x_in,
  input  wire logic signed [qte_pkg::CW-1:0] y_in,
  output logic                             done,
  output logic signed [15:0]               angle
);

  logic signed [qte_pkg::CW-1:0] x, y, xs, ys;
  logic signed [qte_pkg::ZW-1:0] z;
  logic [qte_pkg::IW-1:0]        idx;
  logic                          run;
  logic                          zero;
  logic signed [qte_pkg::ZW-1:0] zr;

  assign xs = x >>> idx;
  assign ys = y >>> idx;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
    end else if (run && idx == qte_pkg::IW'(qte_pkg::CORDIC_ITERS - 1)) begin
      run  <= 1'b0;
      done <= 1'b1;
    end else begin
      done <= 1'b0;
    end
  end

  // vector and angle registers
  always_ff @(posedge clk) begin
    if (start) begin
      idx  <= '0;
      zero <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        z <= (y_in >= 0) ? qte_pkg::PI_Q24 : -qte_pkg::PI_Q24;
        x <= -x_in;
        y <= -y_in;
      end else begin
        z <= '0;
        x <= x_in;
        y <= y_in;
      end
    end else if (run) begin
      idx <= idx + 1'b1;
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + qte_pkg::atan_q24(idx);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - qte_pkg::atan_q24(idx);
      end
    end
  end

  // round to Q3.13 and clamp to +-pi
  always_comb begin
    zr = (z + qte_pkg::ZW'(1024)) >>> 11;
    if (zero) angle = '0;
    else if (zr > qte_pkg::ZW'(qte_pkg::PI_Q13)) angle = qte_pkg::PI_Q13;
    else if (zr < -qte_pkg::ZW'(qte_pkg::PI_Q13)) angle = -qte_pkg::PI_Q13;
    else angle = zr[15:0];
  end

endmodule
`default_nettype wire

// ===== sv/qte_isqrt.sv =====
// Iterative exact integer square root, one result bit per cycle.
`default_nettype none
module qte_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [60:0] v_in,
  output logic             done,
  output logic [30:0]      root
);

  logic [60:0] rem;
  logic [61:0] res, bt, trial;
  logic [4:0]  cnt;
  logic        run;

  assign trial = res + bt;
  assign root  = res[30:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
    end else if (run && cnt == 5'd30) begin
      run  <= 1'b0;
      done <= 1'b1;
    end else begin
      done <= 1'b0;
    end
  end

  // restoring root step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= v_in;
      res <= '0;
      bt  <= 62'(1) << 60;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      bt  <= bt >> 2;
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[60:0];
        res <= (res >> 1) + bt;
      end else begin
        res <= res >> 1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/quaternion_to_euler_yaw_unwrap.sv =====
// Quaternion to ZYX Euler angles with yaw unwrapping, top level.
// Input channel in_word carries one quaternion (w, x, y, z, signed Q1.15);
// output channel out_word carries roll, pitch, wrapped yaw, turn count,
// unwrapped yaw and the pitch clamp flag. A word moves when valid and
// ready are both high.
// One word is processed at a time: in_word.ready is high only while idle.
// From accept to out_word.valid a word passes through the shared 32x32
// multiplier for the quaternion products, the square root behind the asin
// (31 root steps plus start and done), three CORDIC runs of CORDIC_ITERS
// rotations each, and the remaining sequencing states.
// The result is held in out_word until taken; while the receiver stalls
// no new word is accepted. Reset (rst, synchronous) clears the previous
// yaw and turn counter to zero and returns the sequencer to idle.
`default_nettype none
module quaternion_to_euler_yaw_unwrap (
  input wire logic   clk,
  input wire logic   rst,
  qte_in_if.sink     in_word,
  qte_out_if.source  out_word
);

  localparam logic [60:0] ONE_Q60 = 61'(1) << 60;

  qte_pkg::state_t state, state_next;

  // captured inputs and products
  logic signed [15:0] qw, qx, qy, qz;
  logic [3:0]         k;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [32:0] p33;
  logic signed [32:0] ry, rx, yy, sr, yw_y, yw_x;
  logic signed [33:0] s2;
  logic signed [31:0] s_cl, s_reg;
  logic               clamp_cl, clamped;

  // angles and unwrap state
  logic signed [15:0] roll, yaw, prev_yaw, turn_counter, tc_next;
  logic signed [14:0] pitch;
  logic signed [31:0] unwrapped;
  logic signed [16:0] diff;

  // CORDIC (shared by the three angles) and square root units
  logic                          cor_start, cor_done, sq_start, sq_done;
  logic signed [qte_pkg::CW-1:0] cor_x, cor_y;
  logic signed [15:0]            cor_angle;
  logic [30:0]                   sq_root;

  qte_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .done  (cor_done),
    .angle (cor_angle)
  );

  qte_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .v_in  (ONE_Q60 - prod[60:0]),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign p33 = prod[32:0];

  // asin argument, clamped to +-1
  always_comb begin
    s2 = {sr, 1'b0};
    if (s2 > 34'(qte_pkg::ONE_Q30)) begin
      s_cl = qte_pkg::ONE_Q30;
      clamp_cl = 1'b1;
    end else if (s2 < -34'(qte_pkg::ONE_Q30)) begin
      s_cl = -qte_pkg::ONE_Q30;
      clamp_cl = 1'b1;
    end else begin
      s_cl = s2[31:0];
      clamp_cl = 1'b0;
    end
  end

  // turn counter update on large yaw jumps
  always_comb begin
    diff = 17'(yaw) - 17'(prev_yaw);
    tc_next = turn_counter;
    if (diff > qte_pkg::JUMP_LIMIT) begin
      if (turn_counter != 16'sh8000) tc_next = turn_counter - 16'sd1;
    end else if (diff < -qte_pkg::JUMP_LIMIT) begin
      if (turn_counter != 16'sh7fff) tc_next = turn_counter + 16'sd1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      qte_pkg::S_IDLE:       if (in_word.valid) state_next = qte_pkg::S_MUL;
      qte_pkg::S_MUL:        if (k == 4'd9) state_next = qte_pkg::S_SQ;
      qte_pkg::S_SQ:         state_next = qte_pkg::S_SQRT_GO;
      qte_pkg::S_SQRT_GO:    state_next = qte_pkg::S_SQRT_WAIT;
      qte_pkg::S_SQRT_WAIT:  if (sq_done) state_next = qte_pkg::S_ROLL_GO;
      qte_pkg::S_ROLL_GO:    state_next = qte_pkg::S_ROLL_WAIT;
      qte_pkg::S_ROLL_WAIT:  if (cor_done) state_next = qte_pkg::S_PITCH_GO;
      qte_pkg::S_PITCH_GO:   state_next = qte_pkg::S_PITCH_WAIT;
      qte_pkg::S_PITCH_WAIT: if (cor_done) state_next = qte_pkg::S_YAW_GO;
      qte_pkg::S_YAW_GO:     state_next = qte_pkg::S_YAW_WAIT;
      qte_pkg::S_YAW_WAIT:   if (cor_done) state_next = qte_pkg::S_UNW;
      qte_pkg::S_UNW:        state_next = qte_pkg::S_SUM;
      qte_pkg::S_SUM:        state_next = qte_pkg::S_OUT;
      qte_pkg::S_OUT:        if (out_word.ready) state_next = qte_pkg::S_IDLE;
      default:               state_next = qte_pkg::S_IDLE;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    in_word.ready  = (state == qte_pkg::S_IDLE);
    out_word.valid = (state == qte_pkg::S_OUT);
    sq_start  = (state == qte_pkg::S_SQRT_GO);
    cor_start = (state == qte_pkg::S_ROLL_GO) || (state == qte_pkg::S_PITCH_GO) ||
                (state == qte_pkg::S_YAW_GO);
    cor_x = '0;
    cor_y = '0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      qte_pkg::S_MUL: begin
        unique case (k)
          4'd0:    begin mul_a = 32'(qw); mul_b = 32'(qx); end
          4'd1:    begin mul_a = 32'(qy); mul_b = 32'(qz); end
          4'd2:    begin mul_a = 32'(qx); mul_b = 32'(qx); end
          4'd3:    begin mul_a = 32'(qy); mul_b = 32'(qy); end
          4'd4:    begin mul_a = 32'(qw); mul_b = 32'(qy); end
          4'd5:    begin mul_a = 32'(qx); mul_b = 32'(qz); end
          4'd6:    begin mul_a = 32'(qw); mul_b = 32'(qz); end
          4'd7:    begin mul_a = 32'(qx); mul_b = 32'(qy); end
          4'd8:    begin mul_a = 32'(qz); mul_b = 32'(qz); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      qte_pkg::S_SQ: begin
        mul_a = s_cl;
        mul_b = s_cl;
      end
      qte_pkg::S_UNW: begin
        mul_a = 32'(tc_next);
        mul_b = qte_pkg::TWO_PI_Q13;
      end
      qte_pkg::S_ROLL_GO: begin
        cor_x = qte_pkg::CW'(qte_pkg::ONE_Q30) - (qte_pkg::CW'(rx) <<< 1);
        cor_y = qte_pkg::CW'(ry) <<< 1;
      end
      qte_pkg::S_PITCH_GO: begin
        cor_x = qte_pkg::CW'({1'b0, sq_root});
        cor_y = qte_pkg::CW'(s_reg);
      end
      qte_pkg::S_YAW_GO: begin
        cor_x = qte_pkg::CW'(qte_pkg::ONE_Q30) - (qte_pkg::CW'(yw_x) <<< 1);
        cor_y = qte_pkg::CW'(yw_y) <<< 1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= qte_pkg::S_IDLE;
    else state <= state_next;
  end

  // unwrap state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_yaw     <= '0;
      turn_counter <= '0;
    end else if (state == qte_pkg::S_UNW) begin
      prev_yaw     <= yaw;
      turn_counter <= tc_next;
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == qte_pkg::S_IDLE && in_word.valid) begin
      qw <= in_word.quat_w;
      qx <= in_word.quat_x;
      qy <= in_word.quat_y;
      qz <= in_word.quat_z;
      k  <= '0;
    end
    if (state == qte_pkg::S_MUL) begin
      k <= k + 4'd1;
      // accumulate the registered product issued in the previous cycle
      unique case (k)
        4'd1:    ry   <= p33;
        4'd2:    ry   <= ry + p33;
        4'd3:    rx   <= p33;
        4'd4:    begin rx <= rx + p33; yy <= p33; end
        4'd5:    sr   <= p33;
        4'd6:    sr   <= sr - p33;
        4'd7:    yw_y <= p33;
        4'd8:    yw_y <= yw_y + p33;
        4'd9:    yw_x <= yy + p33;
        default: ;
      endcase
    end
    if (state == qte_pkg::S_SQ) begin
      s_reg   <= s_cl;
      clamped <= clamp_cl;
    end
    if (state == qte_pkg::S_ROLL_WAIT && cor_done) roll <= cor_angle;
    if (state == qte_pkg::S_PITCH_WAIT && cor_done) begin
      if (cor_angle > qte_pkg::HALF_PI_Q13) pitch <= qte_pkg::HALF_PI_Q13[14:0];
      else if (cor_angle < -qte_pkg::HALF_PI_Q13) pitch <= 15'(-qte_pkg::HALF_PI_Q13);
      else pitch <= cor_angle[14:0];
    end
    if (state == qte_pkg::S_YAW_WAIT && cor_done) yaw <= cor_angle;
    if (state == qte_pkg::S_SUM) unwrapped <= 32'(yaw) + prod[31:0];
  end

  // result word
  assign out_word.roll_angle    = roll;
  assign out_word.pitch_angle   = pitch;
  assign out_word.yaw_wrapped   = yaw;
  assign out_word.turn_count    = turn_counter;
  assign out_word.yaw_unwrapped = unwrapped;
  assign out_word.pitch_clamped = clamped;

endmodule
`default_nettype wire

// ===== dv/qte_tb_pkg.sv =====
// Testbench types for the quaternion to Euler block checks.
package qte_tb_pkg;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] turns;
    logic signed [31:0] yaw_unw;
    logic               clamped;
  } euler_t;

endpackage

// ===== dv/tb_quaternion_to_euler_yaw_unwrap.sv =====
// Testbench for quaternion_to_euler_yaw_unwrap: random and directed quaternions, scoreboard.
module tb_quaternion_to_euler_yaw_unwrap;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RAND_WORDS     = 1330;

  logic clk;
  logic rst;

  qte_in_if  in_word();
  qte_out_if out_word();

  quaternion_to_euler_yaw_unwrap u_top (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .out_word (out_word)
  );

  qte_tb_pkg::quat_t  pending_quats[$];
  qte_tb_pkg::euler_t expected_angles[$];
  logic signed [15:0] pred_prev_yaw;
  logic signed [15:0] pred_turns;
  int     errors;
  int     idle_cycles;
  bit     stim_done;
  bit     drain_hold;     // sender waits until all results are back
  bit     hold_rx;        // long receiver hold-off request
  int     gap_left;
  int     burst_left;
  int     rx_hold_left;

  // floor shift of a signed value
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                        131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  function automatic longint angle_of(longint yv, longint xv);
    longint zacc;
    longint xs;
    longint ys;
    longint r;
    int     n;
    zacc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      zacc = (yv >= 0) ? 64'sd52707179 : -64'sd52707179;
      xv = -xv;
      yv = -yv;
    end
    n = (qte_pkg::CORDIC_STEPS < 24) ? qte_pkg::CORDIC_STEPS : 24;
    for (int i = 0; i < n; i++) begin
      xs = fshr(xv, i);
      ys = fshr(yv, i);
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        zacc += longint'(atan_step(i));
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        zacc -= longint'(atan_step(i));
      end
    end
    r = fshr(zacc + 1024, 11);
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // Predicts Euler angles and updates the yaw tracking state
  function automatic qte_tb_pkg::euler_t predict_euler(qte_tb_pkg::quat_t q);
    longint w, x, y, z, s, p, yw, d, tc, one;
    qte_tb_pkg::euler_t e;
    one = 64'sd1 << 30;
    w = q.w; x = q.x; y = q.y; z = q.z;
    e.roll = 16'(angle_of(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
    s = 2 * (w * y - x * z);
    e.clamped = 1'b0;
    if (s > one) begin
      s = one; e.clamped = 1'b1;
    end else if (s < -one) begin
      s = -one; e.clamped = 1'b1;
    end
    p = angle_of(s, int_sqrt(longint'(one * one) - s * s));
    if (p > 12868) p = 12868;
    if (p < -12868) p = -12868;
    e.pitch = 15'(p);
    yw = angle_of(2 * (w * z + x * y), one - 2 * (y * y + z * z));
    d = yw - longint'(pred_prev_yaw);
    tc = pred_turns;
    if (d > 12867) begin
      if (tc > -32768) tc -= 1;
    end else if (d < -12867) begin
      if (tc < 32767) tc += 1;
    end
    pred_turns = 16'(tc);
    pred_prev_yaw = 16'(yw);
    e.yaw = 16'(yw);
    e.turns = 16'(tc);
    e.yaw_unw = 32'(yw + tc * 51472);
    return e;
  endfunction

  function automatic logic signed [15:0] rnd_part(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 65535)) >>> $urandom_range(0, 15);
      default: return 16'($urandom_range(0, 1) ? 32767 : -32768);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus
  initial begin
    qte_tb_pkg::quat_t q;
    int ang;
    real th;
    rst = 1'b1;
    // directed corners: identity, extremes, zero, negative axis cases
    pending_quats.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    pending_quats.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
    pending_quats.push_back('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
    pending_quats.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd32767, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
    pending_quats.push_back('{16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
    pending_quats.push_back('{16'sd23170, 16'sd0, -16'sd23170, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd32768});
    pending_quats.push_back('{16'sd100, 16'sd0, 16'sd0, -16'sd32700});
    pending_quats.push_back('{16'sd100, 16'sd0, 16'sd0, 16'sd32700});
    pending_quats.push_back('{-16'sd1, 16'sd1, 16'sd1, -16'sd1});
    // yaw spin sequences mixed with random quaternions: smooth rotation crosses the pi boundary
    for (int n = 0; n < RAND_WORDS; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        ang = (n * 37) % 360;
        if ((n / 200) % 2) ang = 360 - ang;
        th = ang * 3.14159265 / 360.0;
        q.w = 16'($rtoi(32000.0 * $cos(th)) + $signed($urandom_range(0, 200)) - 100);
        q.z = 16'($rtoi(32000.0 * $sin(th)));
        q.x = 16'($signed($urandom_range(0, 4000)) - 2000);
        q.y = 16'($signed($urandom_range(0, 4000)) - 2000);
      end else begin
        q.w = rnd_part($urandom_range(0, 2));
        q.x = rnd_part($urandom_range(0, 2));
        q.y = rnd_part($urandom_range(0, 2));
        q.z = rnd_part($urandom_range(0, 2));
      end
      pending_quats.push_back(q);
    end
    // long drive toward counter saturation is not reachable; spin is enough
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // receiver long hold-off midway
    wait (pending_quats.size() < 900);
    @(posedge clk);
    hold_rx <= 1'b1;
    wait (pending_quats.size() < 600);
    @(posedge clk);
    drain_hold <= 1'b1;
    wait (expected_angles.size() == 0 && !out_word.valid && !in_word.valid);
    @(posedge clk);
    drain_hold <= 1'b0;
    wait (pending_quats.size() == 0 && !in_word.valid);
    stim_done <= 1'b1;
  end

  initial begin
    pred_prev_yaw = '0;
    pred_turns    = '0;
    errors        = 0;
    idle_cycles   = 0;
    stim_done     = 1'b0;
    drain_hold    = 1'b0;
    hold_rx       = 1'b0;
    gap_left      = 0;
    burst_left    = 0;
    rx_hold_left  = 0;
    in_word.valid  = 1'b0;
    in_word.quat_w = '0;
    in_word.quat_x = '0;
    in_word.quat_y = '0;
    in_word.quat_z = '0;
    out_word.ready = 1'b0;
  end

  // Driver: bursts with random gaps
  always @(posedge clk) begin
    qte_tb_pkg::quat_t q;
    if (rst) begin
      in_word.valid <= 1'b0;
    end else begin
      if (in_word.valid && in_word.ready) begin
        expected_angles.push_back(predict_euler({in_word.quat_w, in_word.quat_x,
                                                 in_word.quat_y, in_word.quat_z}));
      end
      if (!in_word.valid || in_word.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_word.valid <= 1'b0;
        end else if (pending_quats.size() != 0 && !drain_hold) begin
          q = pending_quats.pop_front();
          in_word.valid  <= 1'b1;
          in_word.quat_w <= q.w;
          in_word.quat_x <= q.x;
          in_word.quat_y <= q.y;
          in_word.quat_z <= q.z;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_word.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern
  always @(posedge clk) begin
    qte_tb_pkg::euler_t got;
    qte_tb_pkg::euler_t exp_e;
    if (rst) begin
      out_word.ready <= 1'b0;
    end else begin
      if (out_word.valid && out_word.ready) begin
        got = '{out_word.roll_angle, out_word.pitch_angle, out_word.yaw_wrapped,
                out_word.turn_count, out_word.yaw_unwrapped, out_word.pitch_clamped};
        if (expected_angles.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          exp_e = expected_angles.pop_front();
          if (got.roll !== exp_e.roll) begin
            $error("roll_angle exp %0d got %0d", exp_e.roll, got.roll); errors++;
          end
          if (got.pitch !== exp_e.pitch) begin
            $error("pitch_angle exp %0d got %0d", exp_e.pitch, got.pitch); errors++;
          end
          if (got.yaw !== exp_e.yaw) begin
            $error("yaw_wrapped exp %0d got %0d", exp_e.yaw, got.yaw); errors++;
          end
          if (got.turns !== exp_e.turns) begin
            $error("turn_count exp %0d got %0d", exp_e.turns, got.turns); errors++;
          end
          if (got.yaw_unw !== exp_e.yaw_unw) begin
            $error("yaw_unwrapped exp %0d got %0d", exp_e.yaw_unw, got.yaw_unw); errors++;
          end
          if (got.clamped !== exp_e.clamped) begin
            $error("pitch_clamped exp %0d got %0d", exp_e.clamped, got.clamped); errors++;
          end
        end
      end
      if (hold_rx) begin
        hold_rx <= 1'b0;
        rx_hold_left <= 600;
        out_word.ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_word.ready <= 1'b0;
      end else begin
        out_word.ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else if (stim_done && expected_angles.size() == 0 && idle_cycles >= 200) begin
        if (errors == 0 && !out_word.valid) begin
          $display("ALL CHECKS PASSED");
        end else begin
          $display("CHECKS FAILED");
        end
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/qte_pkg.sv
sv/qte_if.sv
sv/qte_cordic.sv
sv/qte_isqrt.sv
sv/quaternion_to_euler_yaw_unwrap.sv
dv/qte_tb_pkg.sv
dv/tb_quaternion_to_euler_yaw_unwrap.sv
